// File: src/siqfc_pkg.sv
// ----------------------------------------------------------------------------
// siqfc_pkg
// Shared types and constants of the sparse-input int8 fully connected layer.
// ----------------------------------------------------------------------------
`default_nettype none

package siqfc_pkg;

  // default geometry
  localparam int IN_LEN_DEF  = 512;
  localparam int OUT_LEN_DEF = 128;

  // mac row: bytes read from each memory per cycle
  localparam int LANES  = 16;
  localparam int LANE_W = 4;

  // word field widths
  localparam int CMD_W       = 2;
  localparam int IN_INDEX_W  = 9;
  localparam int OUT_INDEX_W = 7;
  localparam int BYTE_W      = 8;
  localparam int BIAS_W      = 32;
  localparam int MULT_W      = 32;
  localparam int SHIFT_W     = 6;
  localparam int RESID_W     = 16;
  localparam int RESULT_W    = 16;

  // datapath widths
  localparam int WORD_W  = LANES * BYTE_W;
  localparam int PP_W    = 2 * BYTE_W;
  localparam int ACC_W   = 32;
  localparam int PROD_W  = 64;
  localparam int CLAMP_W = 21;
  localparam int SUM_W   = CLAMP_W + 1;

  localparam logic signed [CLAMP_W-1:0]  CLAMP_MAX  = 21'sd1000000;
  localparam logic signed [CLAMP_W-1:0]  CLAMP_MIN  = -21'sd1000000;
  localparam logic signed [RESULT_W-1:0] RESULT_MAX = 16'sh7fff;
  localparam logic signed [RESULT_W-1:0] RESULT_MIN = 16'sh8000;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_SPARSE  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_MUL,
    ST_RND,
    ST_SHF,
    ST_SAT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: src/siqfc_in_if.sv
// ----------------------------------------------------------------------------
// siqfc_in_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface siqfc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [siqfc_pkg::CMD_W-1:0]       command;
  logic        [siqfc_pkg::IN_INDEX_W-1:0]  in_index;
  logic        [siqfc_pkg::OUT_INDEX_W-1:0] out_index;
  logic signed [siqfc_pkg::BYTE_W-1:0]      byte_value;
  logic signed [siqfc_pkg::BIAS_W-1:0]      bias;
  logic signed [siqfc_pkg::MULT_W-1:0]      mult;
  logic        [siqfc_pkg::SHIFT_W-1:0]     shift;
  logic signed [siqfc_pkg::RESID_W-1:0]     residual;

  modport source (
    output valid, command, in_index, out_index, byte_value, bias, mult, shift, residual,
    input  ready
  );

  modport sink (
    input  valid, command, in_index, out_index, byte_value, bias, mult, shift, residual,
    output ready
  );
endinterface

`default_nettype wire

// File: src/siqfc_out_if.sv
// ----------------------------------------------------------------------------
// siqfc_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface siqfc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [siqfc_pkg::RESULT_W-1:0]    result;
  logic        [siqfc_pkg::OUT_INDEX_W-1:0] result_index;

  modport source (output valid, result, result_index, input ready);
  modport sink   (input valid, result, result_index, output ready);
endinterface

`default_nettype wire

// File: src/sparse_input_quantized_fc_layer.sv
// ----------------------------------------------------------------------------
// sparse_input_quantized_fc_layer
// Int8 fully connected layer with sparse input scatter and int16 residual.
// ----------------------------------------------------------------------------
// Clear, weight write and sparse element commands give no result. A compute
// command reads one 16-byte word of its weight row and one 16-byte word of
// the input vector per cycle into a shared 16-lane multiply-accumulate row;
// the row then drains, and the 32x32 multiply, the rounding add, the shift
// and the clamp and saturate follow as registered steps, then the output
// register loads, waiting while an earlier result has not been taken.
// The weight memory is one word wide of 16 bytes and written one byte at a
// time. Input vector rows carry valid bits, so a clear takes effect at once
// and needs no sweep. A new command is taken while a result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_input_quantized_fc_layer #(
  parameter int IN_LEN  = siqfc_pkg::IN_LEN_DEF,
  parameter int OUT_LEN = siqfc_pkg::OUT_LEN_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  siqfc_in_if.sink      in_i,
  siqfc_out_if.source   out_o
);

  localparam int LANES     = siqfc_pkg::LANES;
  localparam int BYTE_W    = siqfc_pkg::BYTE_W;
  localparam int PP_W      = siqfc_pkg::PP_W;
  localparam int ACC_W     = siqfc_pkg::ACC_W;
  localparam int PROD_W    = siqfc_pkg::PROD_W;
  localparam int SHIFT_W   = siqfc_pkg::SHIFT_W;
  localparam int CLAMP_W   = siqfc_pkg::CLAMP_W;
  localparam int SUM_W     = siqfc_pkg::SUM_W;
  localparam int RESULT_W  = siqfc_pkg::RESULT_W;
  localparam int IDX_W     = siqfc_pkg::IN_INDEX_W;
  localparam int LANE_W    = siqfc_pkg::LANE_W;

  localparam int BEATS      = (IN_LEN + LANES - 1) / LANES;
  localparam int BEAT_W     = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int LAST_LANES = IN_LEN - (BEATS - 1) * LANES;
  localparam int WDEPTH     = OUT_LEN * BEATS;
  localparam int WADDR_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  // ---------------------------------------------------------------- command decode
  siqfc_pkg::state_e state_q, state_d;
  siqfc_pkg::cmd_e   cmd;

  logic                in_acc;
  logic                col_ok, row_ok;
  logic [LANE_W-1:0]   wr_lane;
  logic [BEAT_W-1:0]   wr_beat;
  logic [WADDR_W-1:0]  wr_addr;
  logic                do_wwrite, do_xwrite, do_clear, do_compute;

  assign cmd        = siqfc_pkg::cmd_e'(in_i.command);
  assign in_i.ready = (state_q == siqfc_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign col_ok  = (32'(in_i.in_index) < 32'(IN_LEN));
  assign row_ok  = (32'(in_i.out_index) < 32'(OUT_LEN));
  assign wr_lane = in_i.in_index[LANE_W-1:0];
  assign wr_beat = BEAT_W'(in_i.in_index[IDX_W-1:LANE_W]);
  assign wr_addr = WADDR_W'(in_i.out_index) * WADDR_W'(BEATS) + WADDR_W'(wr_beat);

  assign do_clear   = in_acc && (cmd == siqfc_pkg::CMD_CLEAR);
  assign do_wwrite  = in_acc && (cmd == siqfc_pkg::CMD_WRITE) && col_ok && row_ok;
  assign do_xwrite  = in_acc && (cmd == siqfc_pkg::CMD_SPARSE) && col_ok;
  assign do_compute = in_acc && (cmd == siqfc_pkg::CMD_COMPUTE) && row_ok;

  // ---------------------------------------------------------------- memories
  siqfc_pkg::word_t wmem [WDEPTH];
  siqfc_pkg::word_t xmem [BEATS];
  logic [BEATS-1:0] xvld_q;

  siqfc_pkg::word_t xfill;
  always_comb begin
    xfill = '0;
    xfill[wr_lane*BYTE_W +: BYTE_W] = in_i.byte_value;
  end

  always_ff @(posedge clk_i) begin
    if (do_wwrite) begin
      wmem[wr_addr][wr_lane*BYTE_W +: BYTE_W] <= in_i.byte_value;
    end
  end

  // a row not yet valid since the last clear is written whole, zero filled
  always_ff @(posedge clk_i) begin
    if (do_xwrite) begin
      if (xvld_q[wr_beat]) begin
        xmem[wr_beat][wr_lane*BYTE_W +: BYTE_W] <= in_i.byte_value;
      end else begin
        xmem[wr_beat] <= xfill;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xvld_q <= '0;
    end else if (do_clear) begin
      xvld_q <= '0;
    end else if (do_xwrite) begin
      xvld_q[wr_beat] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic [BEAT_W-1:0]  beat_q, beat_d;
  logic               s1_vld_q, s2_vld_q;
  logic               out_valid_q;
  logic               out_load;

  logic [siqfc_pkg::OUT_INDEX_W-1:0] row_q;
  logic signed [siqfc_pkg::MULT_W-1:0]  mult_q;
  logic [SHIFT_W-1:0]                   shift_q;
  logic signed [siqfc_pkg::RESID_W-1:0] resid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= siqfc_pkg::ST_IDLE;
      beat_q      <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      beat_q   <= beat_d;
      s1_vld_q <= (state_q == siqfc_pkg::ST_MAC);
      s2_vld_q <= s1_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    beat_d   = beat_q;
    out_load = 1'b0;
    case (state_q)
      siqfc_pkg::ST_IDLE: begin
        beat_d = '0;
        if (do_compute) begin
          state_d = siqfc_pkg::ST_MAC;
        end
      end
      siqfc_pkg::ST_MAC: begin
        if (32'(beat_q) == 32'(BEATS - 1)) begin
          state_d = siqfc_pkg::ST_DRAIN;
        end else begin
          beat_d = beat_q + BEAT_W'(1);
        end
      end
      // the last word accumulates on the edge that leaves this state
      siqfc_pkg::ST_DRAIN: begin
        if (!s1_vld_q) begin
          state_d = siqfc_pkg::ST_MUL;
        end
      end
      siqfc_pkg::ST_MUL: state_d = siqfc_pkg::ST_RND;
      siqfc_pkg::ST_RND: state_d = siqfc_pkg::ST_SHF;
      siqfc_pkg::ST_SHF: state_d = siqfc_pkg::ST_SAT;
      siqfc_pkg::ST_SAT: state_d = siqfc_pkg::ST_OUT;
      siqfc_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = siqfc_pkg::ST_IDLE;
        end
      end
      default: state_d = siqfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_compute) begin
      row_q   <= in_i.out_index;
      mult_q  <= in_i.mult;
      shift_q <= in_i.shift;
      resid_q <= in_i.residual;
    end
  end

  // ---------------------------------------------------------------- mac row
  logic [WADDR_W-1:0] rd_addr;
  siqfc_pkg::word_t   w_rd_q, x_rd_q;
  logic               x_ok_q;
  logic [BEAT_W-1:0]  beat1_q;

  assign rd_addr = WADDR_W'(row_q) * WADDR_W'(BEATS) + WADDR_W'(beat_q);

  always_ff @(posedge clk_i) begin
    w_rd_q  <= wmem[rd_addr];
    x_rd_q  <= xmem[beat_q];
    x_ok_q  <= xvld_q[beat_q];
    beat1_q <= beat_q;
  end

  logic signed [PP_W-1:0] pp   [LANES];
  logic signed [PP_W-1:0] pp_q [LANES];
  logic                   last_beat;

  assign last_beat = (32'(beat1_q) == 32'(BEATS - 1));

  // lanes past IN_LEN in the last word or in a row unset since clear count as zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if ((last_beat && (l >= LAST_LANES)) || !x_ok_q) begin
        pp[l] = '0;
      end else begin
        pp[l] = PP_W'($signed(w_rd_q[l*BYTE_W +: BYTE_W]))
              * PP_W'($signed(x_rd_q[l*BYTE_W +: BYTE_W]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      pp_q[l] <= pp[l];
    end
  end

  logic signed [PP_W:0]   lvl1 [LANES/2];
  logic signed [PP_W+1:0] lvl2 [LANES/4];
  logic signed [PP_W+2:0] lvl3 [LANES/8];
  logic signed [PP_W+3:0] lvl4;

  always_comb begin
    for (int i = 0; i < LANES/2; i++) begin
      lvl1[i] = (PP_W+1)'(pp_q[2*i]) + (PP_W+1)'(pp_q[2*i+1]);
    end
    for (int i = 0; i < LANES/4; i++) begin
      lvl2[i] = (PP_W+2)'(lvl1[2*i]) + (PP_W+2)'(lvl1[2*i+1]);
    end
    for (int i = 0; i < LANES/8; i++) begin
      lvl3[i] = (PP_W+3)'(lvl2[2*i]) + (PP_W+3)'(lvl2[2*i+1]);
    end
    lvl4 = (PP_W+4)'(lvl3[0]) + (PP_W+4)'(lvl3[1]);
  end

  // ---------------------------------------------------------------- requantize
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [PROD_W-1:0]   prod_q, rnd_q, v_q;
  logic signed [CLAMP_W-1:0]  clamp;
  logic signed [SUM_W-1:0]    sum;
  logic signed [RESULT_W-1:0] sat, sat_q;

  always_comb begin
    if (v_q > PROD_W'(siqfc_pkg::CLAMP_MAX)) begin
      clamp = siqfc_pkg::CLAMP_MAX;
    end else if (v_q < PROD_W'(siqfc_pkg::CLAMP_MIN)) begin
      clamp = siqfc_pkg::CLAMP_MIN;
    end else begin
      clamp = CLAMP_W'(v_q);
    end
    sum = SUM_W'(clamp) + SUM_W'(resid_q);
    if (sum > SUM_W'(siqfc_pkg::RESULT_MAX)) begin
      sat = siqfc_pkg::RESULT_MAX;
    end else if (sum < SUM_W'(siqfc_pkg::RESULT_MIN)) begin
      sat = siqfc_pkg::RESULT_MIN;
    end else begin
      sat = RESULT_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_compute) begin
      acc_q <= in_i.bias;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + ACC_W'(lvl4);
    end
    if (state_q == siqfc_pkg::ST_MUL) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(mult_q);
    end
    if (state_q == siqfc_pkg::ST_RND) begin
      if (shift_q == '0) begin
        rnd_q <= prod_q;
      end else begin
        rnd_q <= prod_q + (PROD_W'(1) << (shift_q - SHIFT_W'(1)));
      end
    end
    if (state_q == siqfc_pkg::ST_SHF) begin
      v_q <= rnd_q >>> shift_q;
    end
    if (state_q == siqfc_pkg::ST_SAT) begin
      sat_q <= sat;
    end
  end

  // ---------------------------------------------------------------- output word
  logic signed [RESULT_W-1:0]           result_q;
  logic [siqfc_pkg::OUT_INDEX_W-1:0]    result_index_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q       <= sat_q;
      result_index_q <= row_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result       = result_q;
  assign out_o.result_index = result_index_q;

  // ---------------------------------------------------------------- assertions
  a_drained_before_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == siqfc_pkg::ST_MUL) |-> (!s1_vld_q && !s2_vld_q))
    else $error("mac row not drained at requantize");

  a_beat_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == siqfc_pkg::ST_MAC) |-> (32'(beat_q) < 32'(BEATS)))
    else $error("word counter past row end");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_compute |=> (state_q == siqfc_pkg::ST_MAC) && (beat_q == '0))
    else $error("compute did not start the mac row");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == siqfc_pkg::ST_OUT))
    else $error("result word raised outside the output step");

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse-input int8 fully connected layer. Fills
// two weight rows completely, then runs directed words and random
// clear/write/scatter/compute traffic under varying backpressure. Each
// computed output is predicted and compared against the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_LEN      = siqfc_pkg::IN_LEN_DEF;
  localparam int OUT_LEN     = siqfc_pkg::OUT_LEN_DEF;
  localparam int LANES       = siqfc_pkg::LANES;
  localparam int IN_INDEX_W  = siqfc_pkg::IN_INDEX_W;
  localparam int OUT_INDEX_W = siqfc_pkg::OUT_INDEX_W;
  localparam int BYTE_W      = siqfc_pkg::BYTE_W;
  localparam int BIAS_W      = siqfc_pkg::BIAS_W;
  localparam int MULT_W      = siqfc_pkg::MULT_W;
  localparam int SHIFT_W     = siqfc_pkg::SHIFT_W;
  localparam int RESID_W     = siqfc_pkg::RESID_W;
  localparam int RESULT_W    = siqfc_pkg::RESULT_W;
  localparam int LATENCY     = IN_LEN / LANES + 7;
  localparam int LONG_HOLD   = 300;
  localparam int N_ROWS      = 2;
  localparam int RAND_COUNT  = 60;

  typedef struct {
    siqfc_pkg::cmd_e            command;
    logic [IN_INDEX_W-1:0]      in_index;
    logic [OUT_INDEX_W-1:0]     out_index;
    logic signed [BYTE_W-1:0]   byte_value;
    logic signed [BIAS_W-1:0]   bias;
    logic signed [MULT_W-1:0]   mult;
    logic [SHIFT_W-1:0]         shift;
    logic signed [RESID_W-1:0]  residual;
  } fc_cmd_t;

  typedef struct {
    logic signed [RESULT_W-1:0] value;
    logic [OUT_INDEX_W-1:0]     row;
  } fc_result_t;

  class fc_scoreboard;
    logic signed [BYTE_W-1:0] weight_mem [OUT_LEN][IN_LEN];
    logic signed [BYTE_W-1:0] act_vec [IN_LEN];
    fc_result_t               pending [$];
    int                       errors;
    int                       checked;
    int                       n_cmd [4];

    function new();
      foreach (act_vec[k]) act_vec[k] = '0;
      foreach (n_cmd[k]) n_cmd[k] = 0;
      errors  = 0;
      checked = 0;
    endfunction

    // dot product + bias, requantize, add residual, saturate
    function logic signed [RESULT_W-1:0] fc_output(fc_cmd_t w);
      int     acc;
      int     wk;
      int     xk;
      longint prod;
      longint scaled;
      longint total;
      acc = w.bias;
      for (int k = 0; k < IN_LEN; k++) begin
        wk = weight_mem[w.out_index][k];
        xk = act_vec[k];
        acc += wk * xk;
      end
      prod = longint'(acc) * longint'(w.mult);
      // rounding half may wrap past the sign bit before the shift
      if (w.shift == 0) scaled = prod;
      else scaled = (prod + (longint'(1) <<< (w.shift - 1))) >>> w.shift;
      if (scaled > 1000000) scaled = 1000000;
      if (scaled < -1000000) scaled = -1000000;
      total = scaled + longint'(w.residual);
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      return total[RESULT_W-1:0];
    endfunction

    function void note_command(fc_cmd_t w);
      fc_result_t r;
      n_cmd[int'(w.command)]++;
      case (w.command)
        siqfc_pkg::CMD_CLEAR:  foreach (act_vec[k]) act_vec[k] = '0;
        siqfc_pkg::CMD_WRITE:  weight_mem[w.out_index][w.in_index] = w.byte_value;
        siqfc_pkg::CMD_SPARSE: act_vec[w.in_index] = w.byte_value;
        siqfc_pkg::CMD_COMPUTE: begin
          r.value = fc_output(w);
          r.row   = w.out_index;
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic signed [RESULT_W-1:0] value, logic [OUT_INDEX_W-1:0] row);
      fc_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d for row %0d with none outstanding", value, row));
        return;
      end
      exp_r = pending.pop_front();
      if (value !== exp_r.value)
        report($sformatf("row %0d result %0d, predicted %0d", exp_r.row, value, exp_r.value));
      if (row !== exp_r.row)
        report($sformatf("result_index %0d, predicted %0d", row, exp_r.row));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  siqfc_in_if  in_if ();
  siqfc_out_if out_if ();

  sparse_input_quantized_fc_layer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fc_scoreboard sb;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_req = 1'b0;
  // rows that get fully written before any compute reads them
  logic [OUT_INDEX_W-1:0] ready_rows [N_ROWS] = '{7'd0, 7'd127};

  function automatic fc_cmd_t random_word();
    fc_cmd_t w;
    w.command    = siqfc_pkg::cmd_e'($urandom_range(3));
    w.in_index   = IN_INDEX_W'($urandom);
    w.out_index  = OUT_INDEX_W'($urandom);
    w.byte_value = BYTE_W'($urandom);
    w.bias       = $urandom;
    w.mult       = $urandom;
    w.shift      = SHIFT_W'($urandom);
    w.residual   = RESID_W'($urandom);
    return w;
  endfunction

  function automatic fc_cmd_t make_word(siqfc_pkg::cmd_e c, int col, int row, int b);
    fc_cmd_t w;
    w            = random_word();
    w.command    = c;
    w.in_index   = IN_INDEX_W'(col);
    w.out_index  = OUT_INDEX_W'(row);
    w.byte_value = BYTE_W'(b);
    return w;
  endfunction

  function automatic fc_cmd_t compute_word(int row, int bias, int mult, int sh, int res);
    fc_cmd_t w;
    w          = make_word(siqfc_pkg::CMD_COMPUTE, $urandom_range(IN_LEN - 1), row, $urandom);
    w.bias     = bias;
    w.mult     = mult;
    w.shift    = SHIFT_W'(sh);
    w.residual = RESID_W'(res);
    return w;
  endfunction

  function automatic fc_cmd_t random_compute();
    fc_cmd_t w;
    w           = random_word();
    w.command   = siqfc_pkg::CMD_COMPUTE;
    w.out_index = ready_rows[$urandom_range(N_ROWS - 1)];
    if ($urandom_range(3) != 0) w.bias = int'($urandom_range(4000)) - 2000;
    if ($urandom_range(9) < 7) w.shift = SHIFT_W'($urandom_range(50, 20));
    return w;
  endfunction

  // valid stays high across back-to-back words; it drops only on an idle cycle or in wait_drained
  task automatic send_word(fc_cmd_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= w.command;
    in_if.in_index   <= w.in_index;
    in_if.out_index  <= w.out_index;
    in_if.byte_value <= w.byte_value;
    in_if.bias       <= w.bias;
    in_if.mult       <= w.mult;
    in_if.shift      <= w.shift;
    in_if.residual   <= w.residual;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(w);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_rows();
    for (int r = 0; r < N_ROWS; r++) begin
      for (int c = 0; c < IN_LEN; c++) begin
        case (r)
          0:       send_word(make_word(siqfc_pkg::CMD_WRITE, c, ready_rows[r], -128));
          default: send_word(make_word(siqfc_pkg::CMD_WRITE, c, ready_rows[r], $urandom));
        endcase
      end
    end
  endtask

  task automatic run_directed();
    // empty vector: acc is the bias alone
    send_word(make_word(siqfc_pkg::CMD_CLEAR, 0, 0, 0));
    // product 2^62, rounding half at shift 63 wraps the sign
    send_word(compute_word(0, 32'h8000_0000, 32'h8000_0000, 63, 0));
    // no shift: huge products clamp, then saturate high or low
    send_word(compute_word(127, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32767));
    send_word(compute_word(0, 32'h8000_0000, 32'h7fff_ffff, 0, -32768));
    send_word(compute_word(127, 32'h8000_0000, 32'h7fff_ffff, 1, -32768));
    send_word(compute_word(0, 0, 0, 63, -32768));
    // scatter extremes, index 0 overwritten later
    send_word(make_word(siqfc_pkg::CMD_SPARSE, 0, 0, -128));
    send_word(make_word(siqfc_pkg::CMD_SPARSE, IN_LEN - 1, 127, 127));
    send_word(make_word(siqfc_pkg::CMD_SPARSE, 255, 0, -1));
    send_word(make_word(siqfc_pkg::CMD_SPARSE, 0, 127, 127));
    send_word(compute_word(127, 0, 1, 1, 0));
    send_word(compute_word(0, -5, 3, 2, 100));
    send_word(make_word(siqfc_pkg::CMD_WRITE, IN_LEN - 1, 0, 127));
    send_word(make_word(siqfc_pkg::CMD_WRITE, 0, 127, 127));
    send_word(compute_word(0, 0, 1, 1, 0));
    send_word(compute_word(127, 1000, -7, 4, 32767));
    send_word(compute_word(0, 123456, 32'h7fff_ffff, 40, 0));
    send_word(compute_word(127, -123456, 32'h8000_0000, 40, -1));
    send_word(make_word(siqfc_pkg::CMD_CLEAR, IN_LEN - 1, 127, -1));
    send_word(compute_word(127, 77, 1, 1, 5));
  endtask

  task automatic run_random(int count);
    fc_cmd_t w;
    int      pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      w    = random_word();
      if (pick < 3) begin
        w.command = siqfc_pkg::CMD_CLEAR;
      end else if (pick < 33) begin
        w.command = siqfc_pkg::CMD_WRITE;
        if ($urandom_range(1)) w.out_index = ready_rows[$urandom_range(N_ROWS - 1)];
      end else if (pick < 70) begin
        w.command = siqfc_pkg::CMD_SPARSE;
      end else begin
        w = random_compute();
      end
      send_word(w);
    end
  endtask

  // result channel: sample at the edge, then pick ready for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.result, out_if.result_index);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= siqfc_pkg::CMD_CLEAR;
    in_if.in_index   <= '0;
    in_if.out_index  <= '0;
    in_if.byte_value <= '0;
    in_if.bias       <= '0;
    in_if.mult       <= '0;
    in_if.shift      <= '0;
    in_if.residual   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 65;
    load_rows();
    run_directed();
    run_random(RAND_COUNT);

    // stall the result side while computes keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_word(random_compute());
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 18;
    run_random(RAND_COUNT);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RAND_COUNT);
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("covered %0d clears, %0d weight writes, %0d scatters, %0d computes",
             sb.n_cmd[int'(siqfc_pkg::CMD_CLEAR)], sb.n_cmd[int'(siqfc_pkg::CMD_WRITE)],
             sb.n_cmd[int'(siqfc_pkg::CMD_SPARSE)], sb.n_cmd[int'(siqfc_pkg::CMD_COMPUTE)]);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
